>>> hdl/swpc_pkg.sv
`default_nettype none

package swpc_pkg;

    // timestamp store geometry
    localparam int STORE_DEPTH = 1024;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int TIME_W      = 32;

    // reset value of the window length register
    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(60);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [10:0]       count_field_t;

    typedef struct packed {
        time_t event_time;
        logic  clear_peak;
    } in_item_t;

    typedef struct packed {
        count_field_t window_count;
        count_field_t peak_count;
        time_t        peak_first_time;
        time_t        peak_last_time;
        logic         overflow;
    } out_item_t;

    // circular successor of a store index
    function automatic idx_t next_index(input idx_t i);
        idx_t r;
        if (i == IDX_W'(STORE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + IDX_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sliding_window_peak_counter.sv
// Sliding window peak counter. Each input transfer carries a timestamp in seconds
// (non-decreasing) and a clear flag; each one yields exactly one output transfer with
// the number of events inside the window ending at that timestamp, the peak count seen
// since reset or the last clear, the oldest and newest timestamps of that peak window,
// and an overflow flag when the 1024-entry store was full and its oldest live entry had
// to be dropped. The window length is written through cfg_wr_en/cfg_wr_data (reset 60)
// and must only change while the block is idle. Timestamps live in a single-port-read
// synchronous RAM walked by a sequencer: it evicts each expired entry from the head,
// overwrites the oldest entry and fetches the new oldest when the store is full, then
// pushes and reports; each entry is evicted once. Once an item is reported, an output
// register lets a new item be taken while its result waits for out_ready.
`default_nettype none

module sliding_window_peak_counter
    import swpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire time_t     cfg_wr_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    time_t     window_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      slot_free;
    logic      res_valid;
    out_item_t res_data;
    logic      ram_we;
    idx_t      ram_waddr;
    time_t     ram_wdata;
    logic      ram_re;
    idx_t      ram_raddr;
    time_t     ram_rdata;

    // window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_reg <= cfg_wr_data;
        end
    end

    // output slot frees when its transfer completes
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    swpc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_seconds (window_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .slot_free      (slot_free),
        .res_valid      (res_valid),
        .res_data       (res_data),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    swpc_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (TIME_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> hdl/swpc_ram.sv
`default_nettype none

module swpc_ram #(
    parameter  int DEPTH  = 1024,
    parameter  int WIDTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/swpc_ctrl.sv
`default_nettype none

module swpc_ctrl
    import swpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire time_t     window_seconds,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    input  wire logic      slot_free,
    output logic           res_valid,
    output out_item_t      res_data,
    output logic           ram_we,
    output idx_t           ram_waddr,
    output time_t          ram_wdata,
    output logic           ram_re,
    output idx_t           ram_raddr,
    input  wire time_t     ram_rdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_FIRST = 2'd2;

    logic [1:0] state_reg, state_next;
    idx_t       head_reg, head_next;
    idx_t       tail_reg, tail_next;
    cnt_t       live_reg, live_next;
    cnt_t       best_cnt_reg, best_cnt_next;
    time_t      best_first_reg, best_first_next;
    time_t      best_last_reg, best_last_next;
    time_t      t_reg, t_next;

    logic [TIME_W:0] limit;
    logic            too_old;
    logic            full;
    cnt_t            live_inc;
    time_t           first_cand;

    // head entry expires when the new time is past entry plus window
    assign limit    = {1'b0, ram_rdata} + {1'b0, window_seconds};
    assign too_old  = {1'b0, t_reg} > limit;
    assign full     = (live_reg == CNT_W'(STORE_DEPTH));
    assign live_inc = live_reg + CNT_W'(1);
    // an empty window has the new entry as its oldest
    assign first_cand = (live_reg == '0) ? t_reg : ram_rdata;

    // sequencer: accept, evict one head per cycle, push and report
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        live_next       = live_reg;
        best_cnt_next   = best_cnt_reg;
        best_first_next = best_first_reg;
        best_last_next  = best_last_reg;
        t_next          = t_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata       = t_reg;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    t_next = in_data.event_time;
                    ram_re = 1'b1;
                    if (in_data.clear_peak)
                    begin
                        head_next       = '0;
                        tail_next       = '0;
                        live_next       = '0;
                        best_cnt_next   = '0;
                        best_first_next = '0;
                        best_last_next  = '0;
                        ram_raddr       = '0;
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((live_reg != '0) && too_old)
                begin
                    // drop the expired head and fetch the next one
                    head_next = next_index(head_reg);
                    live_next = live_reg - CNT_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = next_index(head_reg);
                end
                else if (full)
                begin
                    // overwrite the oldest entry, fetch the new oldest
                    ram_we     = 1'b1;
                    tail_next  = next_index(tail_reg);
                    head_next  = next_index(head_reg);
                    ram_re     = 1'b1;
                    ram_raddr  = next_index(head_reg);
                    state_next = S_FIRST;
                end
                else if (slot_free)
                begin
                    ram_we    = 1'b1;
                    tail_next = next_index(tail_reg);
                    live_next = live_inc;
                    if (live_inc > best_cnt_reg)
                    begin
                        best_cnt_next   = live_inc;
                        best_first_next = first_cand;
                        best_last_next  = t_reg;
                    end
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIRST:
            begin
                if (slot_free)
                begin
                    if (live_reg > best_cnt_reg)
                    begin
                        best_cnt_next   = live_reg;
                        best_first_next = ram_rdata;
                        best_last_next  = t_reg;
                    end
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result payload from the updated record
    always_comb
    begin
        res_data.window_count    = count_field_t'(live_next);
        res_data.peak_count      = count_field_t'(best_cnt_next);
        res_data.peak_first_time = best_first_next;
        res_data.peak_last_time  = best_last_next;
        res_data.overflow        = (state_reg == S_FIRST);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            live_reg       <= '0;
            best_cnt_reg   <= '0;
            best_first_reg <= '0;
            best_last_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            live_reg       <= live_next;
            best_cnt_reg   <= best_cnt_next;
            best_first_reg <= best_first_next;
            best_last_reg  <= best_last_next;
        end
    end

    // event time of the item in flight
    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

`ifndef SYNTHESIS
    a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(STORE_DEPTH))
        else $error("live count above store depth");

    a_peak_covers_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (best_cnt_reg >= live_reg))
        else $error("peak record below current window count");

    a_first_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIRST) |-> full)
        else $error("overflow step with store not full");

    a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (state_reg == S_IDLE))
        else $error("sequencer busy after reporting");

    a_no_result_without_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> slot_free)
        else $error("result issued while output slot occupied");
`endif

endmodule

`default_nettype wire
